/* hdl/hkv_pkg.sv */
package hkv_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;

  localparam logic [VAL_W-1:0] MINUS_ONE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_REMOVED  = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_HIT      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVIDE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  // one slot as held in the table memory
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

/* hdl/hkv_ram.sv */
module hkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/hkv_rem.sv */
module hkv_rem #(
  parameter int BUCKETS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [hkv_pkg::KEY_W-1:0]      dividend,
  output logic                           done,
  output logic [$clog2(BUCKETS)-1:0]     remainder
);

  localparam int  IDX_W = $clog2(BUCKETS);
  localparam bit  POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

  generate
    if (POW2) begin : g_mask
      // power of two: the remainder is the low bits
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          remainder <= dividend[IDX_W-1:0];
        end
      end
    end else begin : g_recip
      localparam int K_W = hkv_pkg::KEY_W;
      localparam int R_W = IDX_W + 1;
      // scaled reciprocal, floor(2^K_W / BUCKETS); the quotient estimate is
      // at most one short, so the first remainder stays below 2*BUCKETS
      localparam logic [K_W-1:0] RECIP = K_W'((64'd1 << K_W) / BUCKETS);
      localparam logic [K_W-1:0] B_K   = K_W'(BUCKETS);
      localparam logic [R_W-1:0] B_R   = R_W'(BUCKETS);

      logic                 step1;
      logic                 step2;
      logic [K_W-1:0]       key_hold;
      logic [2*K_W-1:0]     product;
      logic [K_W-1:0]       quotient;
      logic [K_W-1:0]       diff;
      logic [R_W-1:0]       rough;
      logic [IDX_W-1:0]     rem_next;

      assign quotient = product[2*K_W-1:K_W];
      assign diff     = key_hold - quotient * B_K;
      assign rem_next = (rough >= B_R) ? IDX_W'(rough - B_R) : rough[IDX_W-1:0];

      // advance the three steps: multiply, subtract, correct
      always_ff @(posedge clk) begin
        if (rst) begin
          step1 <= 1'b0;
          step2 <= 1'b0;
          done  <= 1'b0;
        end else begin
          step1 <= start;
          step2 <= step1;
          done  <= step2;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          key_hold <= dividend;
          product  <= {{K_W{1'b0}}, dividend} * {{K_W{1'b0}}, RECIP};
        end
        if (step1) begin
          rough <= diff[R_W-1:0];
        end
        if (step2) begin
          remainder <= rem_next;
        end
      end
    end
  endgenerate

endmodule

/* hdl/hashed_key_value_table.sv */
// Channel   Handshake                   Payload
// request   req_valid / req_ready       command, key, value
// result    result_valid / result_ready read_value, status
//
// Each request passes through the bucket remainder unit (a mask, or a
// reciprocal multiply, subtract and correction), then reads the ways of
// its bucket one after another from the single-read table RAM, read once
// per way, then decides and writes. One request is in work at a time; no
// new request is taken until the last one has loaded its result.
// After reset a clearing pass marks every slot free; no request is taken
// until it ends. A stalled result holds the block in its final step until
// the result is taken.
module hashed_key_value_table #(
  parameter int BUCKETS = 16,
  parameter int WAYS    = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [hkv_pkg::CMD_W-1:0]          command,
  input  logic [hkv_pkg::KEY_W-1:0]          key,
  input  logic signed [hkv_pkg::VAL_W-1:0]   value,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [hkv_pkg::VAL_W-1:0]   read_value,
  output logic [hkv_pkg::STATUS_W-1:0]       status
);

  localparam int SLOTS  = BUCKETS * WAYS;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int IDX_W  = $clog2(BUCKETS);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [WAY_W-1:0]  WAY_LAST  = WAY_W'(WAYS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(SLOTS - 1);

  hkv_pkg::state_t state, state_next;

  logic [hkv_pkg::CMD_W-1:0] cmd_q;
  logic [hkv_pkg::KEY_W-1:0] key_q;
  logic [hkv_pkg::VAL_W-1:0] val_q;
  logic [ADDR_W-1:0]         base;
  logic [WAY_W-1:0]          issue_way;
  logic                      rd_pend;
  logic [WAY_W-1:0]          rd_way_q;
  logic                      hit;
  logic [WAY_W-1:0]          hit_way;
  logic [hkv_pkg::VAL_W-1:0] hit_value;
  logic                      free_found;
  logic [WAY_W-1:0]          free_way;
  logic [ADDR_W-1:0]         clr_addr;

  logic                      req_accept;
  logic                      mod_done;
  logic [IDX_W-1:0]          bucket;

  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [ADDR_W-1:0]             ram_raddr;
  hkv_pkg::slot_t                wr_slot;
  logic [hkv_pkg::SLOT_W-1:0]    ram_rdata;
  hkv_pkg::slot_t                rd_slot;

  logic                          load;
  logic [hkv_pkg::VAL_W-1:0]     res_value;
  hkv_pkg::status_t              res_status;

  assign req_accept = req_valid && req_ready;
  assign rd_slot    = ram_rdata;
  assign ram_raddr  = base + ADDR_W'(issue_way);

  // bucket index: key modulo BUCKETS
  hkv_rem #(
    .BUCKETS (BUCKETS)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (req_accept),
    .dividend  (key),
    .done      (mod_done),
    .remainder (bucket)
  );

  hkv_ram #(
    .WIDTH (hkv_pkg::SLOT_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_slot),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hkv_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, table writes and result build
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    wr_slot    = '{valid: 1'b1, key: key_q, value: val_q};
    load       = 1'b0;
    res_value  = '0;
    res_status = hkv_pkg::STAT_NOTFOUND;
    unique case (state)
      hkv_pkg::S_CLEAR: begin
        ram_we        = 1'b1;
        wr_slot.valid = 1'b0;
        if (clr_addr == ADDR_LAST) begin
          state_next = hkv_pkg::S_IDLE;
        end
      end
      hkv_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = hkv_pkg::S_DIVIDE;
        end
      end
      hkv_pkg::S_DIVIDE: begin
        if (mod_done) begin
          state_next = hkv_pkg::S_SCAN;
        end
      end
      hkv_pkg::S_SCAN: begin
        if (issue_way == WAY_LAST) begin
          state_next = hkv_pkg::S_DRAIN;
        end
      end
      hkv_pkg::S_DRAIN: begin
        state_next = hkv_pkg::S_DECIDE;
      end
      hkv_pkg::S_DECIDE: begin
        // finish only once the result register is free
        if (!result_valid || result_ready) begin
          load       = 1'b1;
          state_next = hkv_pkg::S_IDLE;
          unique case (cmd_q)
            hkv_pkg::CMD_INSERT: begin
              if (hit) begin
                ram_we     = 1'b1;
                ram_waddr  = base + ADDR_W'(hit_way);
                res_status = hkv_pkg::STAT_UPDATED;
              end else if (free_found) begin
                ram_we     = 1'b1;
                ram_waddr  = base + ADDR_W'(free_way);
                res_status = hkv_pkg::STAT_INSERTED;
              end else begin
                res_status = hkv_pkg::STAT_FULL;
              end
            end
            hkv_pkg::CMD_LOOKUP: begin
              if (hit) begin
                res_value  = hit_value;
                res_status = hkv_pkg::STAT_HIT;
              end else begin
                res_value  = hkv_pkg::MINUS_ONE;
                res_status = hkv_pkg::STAT_NOTFOUND;
              end
            end
            hkv_pkg::CMD_REMOVE: begin
              if (hit) begin
                ram_we        = 1'b1;
                ram_waddr     = base + ADDR_W'(hit_way);
                wr_slot.valid = 1'b0;
                res_status    = hkv_pkg::STAT_REMOVED;
              end
            end
            default: begin
              res_status = hkv_pkg::STAT_NOTFOUND;
            end
          endcase
        end
      end
      default: begin
        state_next = hkv_pkg::S_IDLE;
      end
    endcase
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == hkv_pkg::S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // hold the request
  always_ff @(posedge clk) begin
    if (req_accept) begin
      cmd_q <= command;
      key_q <= key;
      val_q <= value;
    end
  end

  // bucket base and way read sequencing
  always_ff @(posedge clk) begin
    if (state == hkv_pkg::S_DIVIDE && mod_done) begin
      base      <= ADDR_W'(bucket) * ADDR_W'(WAYS);
      issue_way <= '0;
    end else if (state == hkv_pkg::S_SCAN && issue_way != WAY_LAST) begin
      issue_way <= issue_way + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == hkv_pkg::S_SCAN);
    end
    rd_way_q <= issue_way;
  end

  // compare each returned slot: first match and lowest free way
  always_ff @(posedge clk) begin
    if (state == hkv_pkg::S_DIVIDE && mod_done) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_pend) begin
      if (!hit && rd_slot.valid && rd_slot.key == key_q) begin
        hit       <= 1'b1;
        hit_way   <= rd_way_q;
        hit_value <= rd_slot.value;
      end
      if (!free_found && !rd_slot.valid) begin
        free_found <= 1'b1;
        free_way   <= rd_way_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      read_value <= res_value;
      status     <= res_status;
    end
  end

  // no table write while its ways are being read
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == hkv_pkg::S_SCAN || state == hkv_pkg::S_DRAIN) |-> !ram_we)
    else $error("table written during bucket scan");

  // an accepted request blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> !req_ready)
    else $error("request taken while another is in work");

  // a lookup miss returns minus one
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (load && cmd_q == hkv_pkg::CMD_LOOKUP && !hit) |=>
      (read_value == hkv_pkg::MINUS_ONE && result_valid))
    else $error("lookup miss did not return minus one");

  // an insert into a full bucket writes nothing
  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    (load && cmd_q == hkv_pkg::CMD_INSERT && !hit && !free_found) |-> !ram_we)
    else $error("insert into full bucket wrote the table");

endmodule
